>>> sv/adsr_pkg.sv
package adsr_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_EVAL,
        SEQ_DIV,
        SEQ_OUT
    } seq_state_t;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_STEP     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_STEP      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_ENABLE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SUSTAIN_LEVEL   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_SAMPLES = 3'd4;

    localparam int STEP_W      = 24;
    localparam int LEVEL_OUT_W = 24;
    localparam int PHASE_W     = 3;

endpackage

>>> sv/adsr_envelope_generator_core.sv
// Linear ADSR envelope, one gate word in and one level/phase word out per audio sample.
// Level is unsigned fixed point with FRAC_BITS fraction bits (unity = 1 << FRAC_BITS), and
// the level port shows its low 24 bits. The block takes one word at a time: after the input
// handshake it evaluates the sample, then holds the result until the output handshake. The
// sample on which the gate falls from attack, decay or sustain with a nonzero release_samples
// also computes the release step (level / release_samples) with a restoring divide, one
// quotient bit per cycle through the shared add/subtract unit. Configuration registers are
// written through cfg_we/cfg_index/cfg_data; the user must write them only while the block
// is idle, as the block does not enforce it. Indexes past the last register are ignored.
module adsr_envelope_generator_core
    import adsr_pkg::*;
#(
    parameter int FRAC_BITS  = 23,
    parameter int COUNT_BITS = 24
)
(
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 cfg_we,
    input  logic [CFG_INDEX_W-1:0]                               cfg_index,
    input  logic [((COUNT_BITS > STEP_W) ? COUNT_BITS : STEP_W)-1:0] cfg_data,
    input  logic                                                 in_valid,
    output logic                                                 in_ready,
    input  logic                                                 gate,
    output logic                                                 out_valid,
    input  logic                                                 out_ready,
    output logic [LEVEL_OUT_W-1:0]                               level,
    output logic [PHASE_W-1:0]                                   phase
);

    localparam int LW    = FRAC_BITS + 1;
    localparam int SW    = (LW > STEP_W) ? LW : STEP_W;
    localparam int UW    = ((SW > COUNT_BITS + 1) ? SW : COUNT_BITS + 1) + 1;
    localparam int CNT_W = $clog2(LW);

    localparam logic [SW-1:0] ONE_W = {{(SW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [UW-1:0] ONE_U = {{(UW-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic [STEP_W-1:0]     attack_step_reg;
    logic [STEP_W-1:0]     decay_step_reg;
    logic                  decay_enable_reg;
    logic [STEP_W-1:0]     sustain_level_reg;
    logic [COUNT_BITS-1:0] release_samples_reg;

    seq_state_t            seq_reg, seq_next;
    phase_t                phase_reg, phase_next;
    logic [LW-1:0]         level_reg, level_next;
    logic [LW-1:0]         rel_step_reg, rel_step_next;
    logic                  gate_reg, gate_next;
    logic [LW-1:0]         quot_reg, quot_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic [UW-1:0]         alu_a;
    logic [UW-1:0]         alu_b;
    logic                  alu_sub;
    logic [UW-1:0]         alu_res;

    logic [SW-1:0]         sus_w;
    logic [LW-1:0]         sus;
    logic [COUNT_BITS:0]   trial;
    logic [LW-1:0]         quot_shift;
    logic [SW-1:0]         level_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_step_reg     <= STEP_W'(ONE_W);
            decay_step_reg      <= '0;
            decay_enable_reg    <= 1'b0;
            sustain_level_reg   <= STEP_W'(ONE_W);
            release_samples_reg <= COUNT_BITS'(2205);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ATTACK_STEP:     attack_step_reg     <= cfg_data[STEP_W-1:0];
                REG_DECAY_STEP:      decay_step_reg      <= cfg_data[STEP_W-1:0];
                REG_DECAY_ENABLE:    decay_enable_reg    <= cfg_data[0];
                REG_SUSTAIN_LEVEL:   sustain_level_reg   <= cfg_data[STEP_W-1:0];
                REG_RELEASE_SAMPLES: release_samples_reg <= cfg_data[COUNT_BITS-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg      <= SEQ_IDLE;
            phase_reg    <= PH_IDLE;
            level_reg    <= '0;
            rel_step_reg <= '0;
        end
        else
        begin
            seq_reg      <= seq_next;
            phase_reg    <= phase_next;
            level_reg    <= level_next;
            rel_step_reg <= rel_step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gate_reg <= gate_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

    // shared add/subtract unit
    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    assign sus_w = (SW'(sustain_level_reg) > ONE_W) ? ONE_W : SW'(sustain_level_reg);
    assign sus   = sus_w[LW-1:0];
    assign trial = {rem_reg, quot_reg[LW-1]};

    always_comb
    begin
        seq_next      = seq_reg;
        phase_next    = phase_reg;
        level_next    = level_reg;
        rel_step_next = rel_step_reg;
        gate_next     = gate_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        alu_a         = '0;
        alu_b         = '0;
        alu_sub       = 1'b0;
        quot_shift    = '0;

        case (seq_reg)
            SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    gate_next = gate;
                    seq_next  = SEQ_EVAL;
                end
            end

            SEQ_EVAL:
            begin
                seq_next = SEQ_OUT;
                if (gate_reg)
                begin
                    case (phase_reg)
                        PH_ATTACK:
                        begin
                            alu_a   = UW'(level_reg);
                            alu_b   = UW'(attack_step_reg);
                            alu_sub = 1'b0;
                            if (alu_res >= ONE_U)
                            begin
                                level_next = ONE_W[LW-1:0];
                                phase_next = decay_enable_reg ? PH_DECAY : PH_SUSTAIN;
                            end
                            else
                            begin
                                level_next = alu_res[LW-1:0];
                            end
                        end
                        PH_DECAY:
                        begin
                            alu_a   = UW'(level_reg);
                            alu_b   = UW'(decay_step_reg);
                            alu_sub = 1'b1;
                            if ($signed(alu_res) <= $signed(UW'(sus)))
                            begin
                                level_next = sus;
                                phase_next = PH_SUSTAIN;
                            end
                            else
                            begin
                                level_next = alu_res[LW-1:0];
                            end
                        end
                        PH_SUSTAIN:
                        begin
                            level_next = sus;
                        end
                        default:
                        begin
                            phase_next = PH_ATTACK;
                            level_next = '0;
                        end
                    endcase
                end
                else
                begin
                    case (phase_reg)
                        PH_ATTACK, PH_DECAY, PH_SUSTAIN:
                        begin
                            phase_next = PH_RELEASE;
                            if (release_samples_reg != '0)
                            begin
                                quot_next = level_reg;
                                rem_next  = '0;
                                cnt_next  = CNT_W'(LW - 1);
                                seq_next  = SEQ_DIV;
                            end
                            else
                            begin
                                rel_step_next = level_reg;
                            end
                        end
                        PH_RELEASE:
                        begin
                            alu_a   = UW'(level_reg);
                            alu_b   = UW'(rel_step_reg);
                            alu_sub = 1'b1;
                            if (alu_res[UW-1] || (alu_res == '0))
                            begin
                                if ((rel_step_reg != '0) || (level_reg == '0))
                                begin
                                    level_next = '0;
                                    phase_next = PH_IDLE;
                                end
                            end
                            else
                            begin
                                level_next = alu_res[LW-1:0];
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            level_next = '0;
                        end
                    endcase
                end
            end

            SEQ_DIV:
            begin
                // one restoring divide step per cycle
                alu_a   = UW'(trial);
                alu_b   = UW'(release_samples_reg);
                alu_sub = 1'b1;
                if (!alu_res[UW-1])
                begin
                    rem_next   = alu_res[COUNT_BITS-1:0];
                    quot_shift = {quot_reg[LW-2:0], 1'b1};
                end
                else
                begin
                    rem_next   = trial[COUNT_BITS-1:0];
                    quot_shift = {quot_reg[LW-2:0], 1'b0};
                end
                quot_next = quot_shift;
                if (cnt_reg == '0)
                begin
                    rel_step_next = quot_shift;
                    seq_next      = SEQ_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            SEQ_OUT:
            begin
                if (out_ready)
                begin
                    seq_next = SEQ_IDLE;
                end
            end

            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    assign in_ready  = (seq_reg == SEQ_IDLE);
    assign out_valid = (seq_reg == SEQ_OUT);
    assign level_w   = SW'(level_reg);
    assign level     = level_w[LEVEL_OUT_W-1:0];
    assign phase     = phase_reg;

endmodule

>>> sv/adsr_chk.sv
module adsr_chk
    import adsr_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   gate,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [LEVEL_OUT_W-1:0] level,
    input logic [PHASE_W-1:0]     phase
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level) && $stable(phase))
        else $error("output word changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready && !out_valid)
        else $error("accepted word not processed");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase == PH_IDLE) |-> (level == '0))
        else $error("idle phase with nonzero level");

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready && !out_valid)
        else $error("not ready after result taken");

endmodule

bind adsr_envelope_generator_core adsr_chk u_adsr_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .gate      (gate),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level     (level),
    .phase     (phase)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import adsr_pkg::*;

    localparam bit [23:0] UNITY             = 24'd8388608;
    localparam int        CYCLE_LIMIT       = 600000;
    localparam int        RANDOM_SETTINGS   = 12;
    localparam int        WORDS_PER_SETTING = 135;
    localparam int        LONG_HOLD_CYCLES  = 300;

    typedef struct {
        bit [23:0] lvl;
        phase_t    ph;
    } envelope_word_t;

    typedef struct {
        bit                     is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        bit [23:0]              data;
        bit                     g;
        bit                     known;
        envelope_word_t         want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [23:0]            cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   gate;
    logic                   out_valid;
    logic                   out_ready;
    logic [LEVEL_OUT_W-1:0] level;
    logic [PHASE_W-1:0]     phase;

    // envelope predictor state and register copy
    phase_t    env_phase;
    bit [23:0] env_level;
    bit [23:0] rel_step;
    bit [23:0] atk_step;
    bit [23:0] dec_step;
    bit        dec_en;
    bit [23:0] sus_level;
    bit [23:0] rel_count;

    envelope_word_t envelope_q[$];
    stim_row_t      stim_rows[$];

    int  cycle_count   = 0;
    int  words_sent    = 0;
    int  words_checked = 0;
    int  mismatches    = 0;
    int  settings_run  = 0;
    int  long_holds    = 0;
    int  phase_hits[5] = '{0, 0, 0, 0, 0};
    bit  send_gaps     = 1'b1;
    bit  recv_stalls   = 1'b1;
    bit  hold_out      = 1'b0;

    adsr_envelope_generator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .gate      (gate),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .level     (level),
        .phase     (phase)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void reset_envelope();
        env_phase = PH_IDLE;
        env_level = 24'd0;
        rel_step  = 24'd0;
        atk_step  = UNITY;
        dec_step  = 24'd0;
        dec_en    = 1'b0;
        sus_level = UNITY;
        rel_count = 24'd2205;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx, input bit [23:0] data);
        case (idx)
            REG_ATTACK_STEP:     atk_step  = data;
            REG_DECAY_STEP:      dec_step  = data;
            REG_DECAY_ENABLE:    dec_en    = data[0];
            REG_SUSTAIN_LEVEL:   sus_level = data;
            REG_RELEASE_SAMPLES: rel_count = data;
            default: ;
        endcase
    endfunction

    function automatic envelope_word_t next_envelope(input bit g);
        bit [24:0]      sum;
        bit [23:0]      sus;
        int             lv;
        int             ds;
        int             sus_i;
        envelope_word_t res;
        sus   = (sus_level > UNITY) ? UNITY : sus_level;
        sus_i = int'(sus);
        if (g)
        begin
            case (env_phase)
                PH_ATTACK:
                begin
                    sum = {1'b0, env_level} + {1'b0, atk_step};
                    if (sum >= {1'b0, UNITY})
                    begin
                        env_level = UNITY;
                        if (dec_en)
                            env_phase = PH_DECAY;
                        else
                            env_phase = PH_SUSTAIN;
                    end
                    else
                        env_level = sum[23:0];
                end
                PH_DECAY:
                begin
                    lv = int'(env_level);
                    ds = int'(dec_step);
                    if (lv - ds <= sus_i)
                    begin
                        env_level = sus;
                        env_phase = PH_SUSTAIN;
                    end
                    else
                        env_level = env_level - dec_step;
                end
                PH_SUSTAIN: env_level = sus;
                default:
                begin
                    env_phase = PH_ATTACK;
                    env_level = 24'd0;
                end
            endcase
        end
        else
        begin
            case (env_phase)
                PH_ATTACK, PH_DECAY, PH_SUSTAIN:
                begin
                    env_phase = PH_RELEASE;
                    if (rel_count != 0)
                        rel_step = env_level / rel_count;
                    else
                        rel_step = env_level;
                end
                PH_RELEASE:
                begin
                    if (env_level <= rel_step)
                    begin
                        if (rel_step != 0 || env_level == 0)
                        begin
                            env_level = 24'd0;
                            env_phase = PH_IDLE;
                        end
                    end
                    else
                        env_level = env_level - rel_step;
                end
                default:
                begin
                    env_phase = PH_IDLE;
                    env_level = 24'd0;
                end
            endcase
        end
        res.lvl = env_level;
        res.ph  = env_phase;
        return res;
    endfunction

    function automatic void cfg_row(input logic [CFG_INDEX_W-1:0] idx, input bit [23:0] data);
        stim_row_t row;
        row.is_cfg   = 1'b1;
        row.idx      = idx;
        row.data     = data;
        row.g        = 1'b0;
        row.known    = 1'b0;
        row.want.lvl = 24'd0;
        row.want.ph  = PH_IDLE;
        stim_rows.push_back(row);
    endfunction

    function automatic void known_row(input bit g, input bit [23:0] lvl, input phase_t ph);
        stim_row_t row;
        row.is_cfg   = 1'b0;
        row.idx      = REG_ATTACK_STEP;
        row.data     = 24'd0;
        row.g        = g;
        row.known    = 1'b1;
        row.want.lvl = lvl;
        row.want.ph  = ph;
        stim_rows.push_back(row);
    endfunction

    function automatic void word_row(input bit g);
        known_row(g, 24'd0, PH_IDLE);
        stim_rows[stim_rows.size() - 1].known = 1'b0;
    endfunction

    task automatic report_error(input string field, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR word %0d %s: expected %0d, got %0d", words_checked, field, want, got);
    endtask

    task automatic check_envelope();
        envelope_word_t want;
        words_checked++;
        if (phase <= PH_RELEASE)
            phase_hits[phase]++;
        if (envelope_q.size() == 0)
        begin
            report_error("unexpected word, level", 0, level);
            return;
        end
        want = envelope_q.pop_front();
        if (level !== want.lvl)
            report_error("level", want.lvl, level);
        if (phase !== want.ph)
            report_error("phase", want.ph, phase);
    endtask

    task automatic send_word(input bit g, input bit known, input envelope_word_t want);
        int             gap;
        envelope_word_t pred;
        gap = send_gaps ? $urandom_range(0, 8) : 0;
        cfg_we <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        gate     <= g;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pred = next_envelope(g);
        if (known)
            envelope_q.push_back(want);
        else
            envelope_q.push_back(pred);
        words_sent++;
    endtask

    // hold until every word is back and the block takes input again
    task automatic drain();
        in_valid <= 1'b0;
        while (envelope_q.size() != 0 || !in_ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input bit [23:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
    endtask

    task automatic pick_envelope_setting();
        bit [23:0] v;
        drain();
        case ($urandom_range(0, 5))
            0:       v = UNITY;
            1:       v = 24'($urandom_range(1, UNITY));
            2:       v = 24'd1;
            default: v = 24'($urandom_range(UNITY / 48, UNITY / 2));
        endcase
        write_reg(REG_ATTACK_STEP, v);
        case ($urandom_range(0, 5))
            0:       v = 24'd0;
            1:       v = UNITY;
            2:       v = 24'($urandom_range(0, UNITY));
            default: v = 24'($urandom_range(UNITY / 40, UNITY / 4));
        endcase
        write_reg(REG_DECAY_STEP, v);
        write_reg(REG_DECAY_ENABLE, ($urandom_range(0, 2) != 0) ? 24'd1 : 24'd0);
        case ($urandom_range(0, 5))
            0:       v = 24'd0;
            1:       v = UNITY;
            2:       v = 24'($urandom_range(UNITY + 1, 24'hFFFFFF));
            default: v = 24'($urandom_range(0, UNITY));
        endcase
        write_reg(REG_SUSTAIN_LEVEL, v);
        case ($urandom_range(0, 6))
            0:       v = 24'd0;
            1:       v = 24'hFFFFFF;
            2:       v = 24'($urandom_range(0, 24'hFFFFFF));
            default: v = 24'($urandom_range(1, 40));
        endcase
        write_reg(REG_RELEASE_SAMPLES, v);
        settings_run++;
    endtask

    // notes: gate held for a stretch, then released; some stretches are gate noise
    task automatic play_notes(input int count);
        int             n;
        int             len;
        int             k;
        bit             noisy;
        bit             g;
        envelope_word_t none;
        none.lvl = 24'd0;
        none.ph  = PH_IDLE;
        n = 0;
        while (n < count)
        begin
            noisy = ($urandom_range(0, 99) < 15);
            len   = $urandom_range(1, 60);
            for (k = 0; k < len && n < count; k++)
            begin
                g = noisy ? 1'($urandom_range(0, 1)) : 1'b1;
                send_word(g, 1'b0, none);
                n++;
            end
            if (!noisy)
            begin
                len = $urandom_range(1, 50);
                for (k = 0; k < len && n < count; k++)
                begin
                    send_word(1'b0, 1'b0, none);
                    n++;
                end
            end
        end
    endtask

    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = recv_stalls ? $urandom_range(0, 8) : 0;
            if (hold_out)
            begin
                hold_out = 1'b0;
                stall    = LONG_HOLD_CYCLES;
                long_holds++;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            check_envelope();
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_ATTACK_STEP;
        cfg_data  <= 24'd0;
        in_valid  <= 1'b0;
        gate      <= 1'b0;
        reset_envelope();

        known_row(1'b0, 24'd0, PH_IDLE);
        known_row(1'b1, 24'd0, PH_ATTACK);
        known_row(1'b1, UNITY, PH_SUSTAIN);
        known_row(1'b0, UNITY, PH_RELEASE);
        word_row(1'b0);
        known_row(1'b1, 24'd0, PH_ATTACK);
        cfg_row(REG_ATTACK_STEP, 24'd3000000);
        cfg_row(REG_DECAY_STEP, UNITY);
        cfg_row(REG_DECAY_ENABLE, 24'd1);
        cfg_row(REG_SUSTAIN_LEVEL, 24'd0);
        known_row(1'b1, 24'd3000000, PH_ATTACK);
        known_row(1'b1, 24'd6000000, PH_ATTACK);
        known_row(1'b1, UNITY, PH_DECAY);
        known_row(1'b1, 24'd0, PH_SUSTAIN);
        cfg_row(REG_RELEASE_SAMPLES, 24'd0);
        known_row(1'b0, 24'd0, PH_RELEASE);
        known_row(1'b0, 24'd0, PH_IDLE);
        cfg_row(REG_SUSTAIN_LEVEL, 24'hFFFFFF);
        cfg_row(REG_DECAY_STEP, 24'd1000);
        known_row(1'b1, 24'd0, PH_ATTACK);
        word_row(1'b1);
        word_row(1'b1);
        known_row(1'b1, UNITY, PH_DECAY);
        known_row(1'b1, UNITY, PH_SUSTAIN);
        known_row(1'b0, UNITY, PH_RELEASE);
        known_row(1'b0, 24'd0, PH_IDLE);
        cfg_row(REG_RELEASE_SAMPLES, 24'hFFFFFF);
        cfg_row(REG_ATTACK_STEP, 24'd1);
        known_row(1'b1, 24'd0, PH_ATTACK);
        known_row(1'b1, 24'd1, PH_ATTACK);
        known_row(1'b0, 24'd1, PH_RELEASE);
        known_row(1'b0, 24'd1, PH_RELEASE);
        known_row(1'b1, 24'd0, PH_ATTACK);
        cfg_row(REG_ATTACK_STEP, 24'd0);
        known_row(1'b1, 24'd0, PH_ATTACK);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].is_cfg)
            begin
                drain();
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            end
            else
                send_word(stim_rows[i].g, stim_rows[i].known, stim_rows[i].want);
        end

        for (int s = 0; s < RANDOM_SETTINGS; s++)
        begin
            pick_envelope_setting();
            send_gaps   = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            if (s == 2 || s == 9)
                hold_out = 1'b1;
            play_notes(WORDS_PER_SETTING / 2);
            if (s % 4 == 1)
                drain();
            play_notes(WORDS_PER_SETTING - WORDS_PER_SETTING / 2);
        end

        drain();
        repeat (40) @(posedge clk);
        $display("Sent %0d gate words, checked %0d, over %0d random register settings,",
                 words_sent, words_checked, settings_run);
        $display("%0d long output holds; phases seen idle/attack/decay/sustain/release: %0d/%0d/%0d/%0d/%0d",
                 long_holds, phase_hits[0], phase_hits[1], phase_hits[2], phase_hits[3],
                 phase_hits[4]);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
